// ----- design/twrbm_pkg.sv -----
// Shared types, constants and the tempering function for the twister unit.
// No dependencies.
package twrbm_pkg;

   localparam int unsigned DEPTH     = 624;
   localparam int unsigned SHIFT     = 397;
   localparam int unsigned AW        = 10;
   localparam int unsigned CW        = 5;

   localparam logic [31:0] SEED_MUL     = 32'h0001_0dcd;
   localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
   localparam logic [31:0] MASK_B       = 32'h9d2c_56ff;
   localparam logic [31:0] MASK_C       = 32'hefc6_7fff;

   localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
   localparam logic [AW-1:0] WRAP_IDX  = AW'(DEPTH - SHIFT);
   localparam logic [AW-1:0] SHIFT_IDX = AW'(SHIFT);
   localparam logic [CW-1:0] DIV_LAST  = '1;

   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_SEED = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_TW_PRE,
      ST_TW_RD,
      ST_TW_WR,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic draw_load;
      logic seed_load;
      logic seed_step;
      logic tw_init;
      logic tw_read;
      logic tw_write;
      logic word_read;
      logic temper_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic need_twist;
      logic seed_last;
      logic tw_last;
      logic div_last;
      logic out_free;
   } status_type;

   function automatic logic [31:0] temper(input logic [31:0] x_in);
      logic [31:0] x;
      x = x_in ^ (x_in >> 11);
      x = x ^ ((x << 7) & MASK_B);
      x = x ^ ((x << 15) & MASK_C);
      return x ^ (x >> 18);
   endfunction

endpackage

// ----- design/twrbm_ctrl.sv -----
// Sequencer for seed fill, whole-array twist, word read and remainder.
// Depends on twrbm_pkg.
module twrbm_ctrl import twrbm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_op,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_SEED) state_in = ST_SEED;
               else if (status.need_twist) state_in = ST_TW_PRE;
               else state_in = ST_RD_ADDR;
            end
         end
         ST_SEED:    if (status.seed_last) state_in = ST_IDLE;
         ST_TW_PRE:  state_in = ST_TW_RD;
         ST_TW_RD:   state_in = ST_TW_WR;
         ST_TW_WR:   state_in = status.tw_last ? ST_RD_ADDR : ST_TW_RD;
         ST_RD_ADDR: state_in = ST_RD_DATA;
         ST_RD_DATA: state_in = ST_DIV;
         ST_DIV:     if (status.div_last) state_in = ST_OUT;
         ST_OUT:     if (status.out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            cmd.draw_load = req_valid && (req_op == OP_DRAW);
            cmd.seed_load = req_valid && (req_op == OP_SEED);
         end
         ST_SEED:    cmd.seed_step   = 1'b1;
         ST_TW_PRE:  cmd.tw_init     = 1'b1;
         ST_TW_RD:   cmd.tw_read     = 1'b1;
         ST_TW_WR:   cmd.tw_write    = 1'b1;
         ST_RD_ADDR: cmd.word_read   = 1'b1;
         ST_RD_DATA: cmd.temper_load = 1'b1;
         ST_DIV:     cmd.div_step    = 1'b1;
         ST_OUT:     cmd.out_load    = status.out_free;
         default:    cmd = '0;
      endcase
   end

   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.draw_load || cmd.seed_load) |-> (state_ff == ST_IDLE))
      else $error("beat taken outside idle");
   a_twist_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TW_WR && status.tw_last) |=> (state_ff == ST_RD_ADDR))
      else $error("twist did not end in word read");
   a_div_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && status.div_last) |=> (state_ff == ST_OUT))
      else $error("remainder did not reach output");

endmodule

// ----- design/twrbm_dp.sv -----
// Datapath: word memory, seed multiplier, twist, tempering, restoring remainder
// and output register. Depends on twrbm_pkg.
module twrbm_dp import twrbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [31:0] req_seed_value,
   input  logic [31:0] req_modulus,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_number,
   output logic        rsp_zero_modulus
);

   logic [31:0] mem [0:DEPTH-1];

   logic               seeded_ff;
   logic [AW-1:0]      cursor_ff;
   logic signed [10:0] remain_ff;
   logic [AW-1:0]      rd_addr_ff;
   logic [AW-1:0]      idx_ff;
   logic [31:0]        v_ff;
   logic [31:0]        mod_ff;
   logic [31:0]        rda_ff, rdb_ff, cur_ff;
   logic [31:0]        tval_ff, dvd_ff, rem_ff;
   logic [CW-1:0]      cnt_ff;
   logic               rsp_valid_ff;
   logic [31:0]        number_ff;
   logic               zero_ff;

   logic [AW-1:0] draw_addr, nxt_idx, far_idx, addr_a;
   logic [31:0]   y, tw_word, wr_data;
   logic [AW-1:0] wr_addr;
   logic          wr_en, rd_en, out_free;
   logic [63:0]   prod;
   logic [32:0]   trial, diff;

   // exhausted: a seeded array is twisted and word 0 is used; otherwise restart at 1
   assign draw_addr = (remain_ff == 11'sd0) ? (seeded_ff ? '0 : AW'(1)) : cursor_ff;
   assign nxt_idx   = (idx_ff == LAST_IDX) ? '0 : idx_ff + AW'(1);
   assign far_idx   = (idx_ff < WRAP_IDX) ? idx_ff + SHIFT_IDX : idx_ff - WRAP_IDX;
   assign y         = {cur_ff[31], rda_ff[30:0]};
   assign tw_word   = rdb_ff ^ (y >> 1) ^ (rda_ff[0] ? TWIST_MATRIX : 32'h0);
   assign prod      = v_ff * SEED_MUL;
   assign out_free  = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      addr_a = rd_addr_ff;
      rd_en  = 1'b0;
      if (cmd.tw_init) begin
         addr_a = '0;
         rd_en  = 1'b1;
      end else if (cmd.tw_read) begin
         addr_a = nxt_idx;
         rd_en  = 1'b1;
      end else if (cmd.word_read) begin
         rd_en  = (rd_addr_ff <= LAST_IDX);
      end
   end

   assign wr_en   = cmd.seed_step || cmd.tw_write;
   assign wr_addr = idx_ff;
   assign wr_data = cmd.seed_step ? v_ff : tw_word;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rda_ff <= mem[addr_a];
      if (cmd.tw_read) rdb_ff <= mem[far_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.seed_load) begin
         v_ff   <= req_seed_value | 32'h1;
         idx_ff <= '0;
      end else if (cmd.seed_step) begin
         v_ff   <= prod[31:0];
         idx_ff <= idx_ff + AW'(1);
      end else if (cmd.tw_init) begin
         idx_ff <= '0;
      end else if (cmd.tw_write) begin
         idx_ff <= nxt_idx;
      end
      if (cmd.tw_read) cur_ff <= rda_ff;
      if (cmd.draw_load) begin
         mod_ff     <= req_modulus;
         rd_addr_ff <= draw_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
         cursor_ff <= '0;
         remain_ff <= '0;
      end else if (cmd.seed_step && idx_ff == LAST_IDX) begin
         seeded_ff <= 1'b1;
         remain_ff <= '0;
      end else if (cmd.draw_load) begin
         cursor_ff <= draw_addr + AW'(1);
         remain_ff <= (remain_ff == 11'sd0) ? 11'(DEPTH - 1) : remain_ff - 11'sd1;
      end
   end

   // restoring remainder, one dividend bit per cycle
   assign trial = {rem_ff, dvd_ff[31]};
   assign diff  = trial - {1'b0, mod_ff};

   always_ff @(posedge clock) begin
      if (cmd.temper_load) begin
         tval_ff <= temper(seeded_ff ? rda_ff : 32'h0);
         dvd_ff  <= temper(seeded_ff ? rda_ff : 32'h0);
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= diff[32] ? trial[31:0] : diff[31:0];
         dvd_ff  <= dvd_ff << 1;
         cnt_ff  <= cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         number_ff <= (mod_ff == 32'h0) ? tval_ff : rem_ff;
         zero_ff   <= (mod_ff == 32'h0);
      end
   end

   assign status.need_twist = (remain_ff == 11'sd0) && seeded_ff;
   assign status.seed_last  = (idx_ff == LAST_IDX);
   assign status.tw_last    = (idx_ff == LAST_IDX);
   assign status.div_last   = (cnt_ff == DIV_LAST);
   assign status.out_free   = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_number       = number_ff;
   assign rsp_zero_modulus = zero_ff;

   a_remain_range: assert property (@(posedge clock) disable iff (reset)
      (remain_ff >= 11'sd0) && (remain_ff <= 11'sd623))
      else $error("words remaining out of range");
   a_seed_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.seed_step && idx_ff == LAST_IDX) |=> (seeded_ff && remain_ff == 11'sd0))
      else $error("seed fill did not arm twist");
   a_twist_seeded: assert property (@(posedge clock) disable iff (reset)
      cmd.tw_write |-> seeded_ff)
      else $error("twist before seeding");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("output overwritten while stalled");

endmodule

// ----- design/twister_random_below_modulus_unit.sv -----
// Twister random source: 624-word Mersenne Twister with remainder below a modulus.
// A req beat with op=1 reseeds (no rsp beat); op=0 draws and gives one rsp beat
// carrying the tempered word modulo req_modulus, or the tempered word with
// rsp_zero_modulus set when the modulus is zero.
// Seed: while in work, the seed multiplier writes one word per cycle.
// Draw: memory read, temper, then a restoring remainder one bit per cycle,
// then the output load, which waits while the output register is full; the
// next beat is taken only once the unit is back in idle.
// The first draw after a seed and every 624th draw after it first twist the
// whole array over the single memory: one setup state, then a read state
// and a write state per word.
// req_stall is high while an item is in work; one item is handled at a time.
// The result sits in an output register, so a stalled rsp side does not block
// acceptance of the next item; only the final load waits for the register to free.
// Reset (synchronous, active high) returns to idle, unseeded; draws before the
// first seed return 0 whatever the memory holds, so no clearing pass is needed.
module twister_random_below_modulus_unit import twrbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_seed_value,
   input  logic [31:0] req_modulus,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_number,
   output logic        rsp_zero_modulus
);

   cmd_type    cmd;
   status_type status;

   twrbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   twrbm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_seed_value   (req_seed_value),
      .req_modulus      (req_modulus),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_number       (rsp_number),
      .rsp_zero_modulus (rsp_zero_modulus)
   );

endmodule

// ----- tb/twister_random_below_modulus_unit_tb.sv -----
// Testbench for the twister random unit: directed table then random seed/draw beats,
// each response checked against a behavioral predictor kept in this file.
// Depends on twrbm_pkg and twister_random_below_modulus_unit.
module twister_random_below_modulus_unit_tb;
   import twrbm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        op;
      logic [31:0] seed_value;
      logic [31:0] modulus;
      logic        has_known;
      logic [31:0] known_number;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] number;
      logic        zero_modulus;
   } draw_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_DRAW;
   logic [31:0] req_seed_value = '0;
   logic [31:0] req_modulus = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_number;
   logic        rsp_zero_modulus;

   twister_random_below_modulus_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_seed_value(req_seed_value), .req_modulus(req_modulus),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_number(rsp_number), .rsp_zero_modulus(rsp_zero_modulus)
   );

   // predictor state
   logic [31:0] mt_words [DEPTH];
   logic [9:0]  mt_cursor;
   int          mt_left;
   bit          mt_seeded;

   draw_result_type pending_draws [$];
   int  mismatch_count = 0;
   bit  stall_hold = 1'b0;

   function automatic logic [31:0] mt_temper(input logic [31:0] v);
      logic [31:0] x;
      x = v ^ (v >> 11);
      x = x ^ ((x << 7) & MASK_B);
      x = x ^ ((x << 15) & MASK_C);
      return x ^ (x >> 18);
   endfunction

   task automatic mt_clear();
      foreach (mt_words[i]) mt_words[i] = '0;
      mt_cursor = '0;
      mt_left   = 0;
      mt_seeded = 1'b0;
   endtask

   task automatic mt_seed(input logic [31:0] s);
      logic [31:0] v;
      v = s | 32'd1;
      mt_words[0] = v;
      for (int i = 1; i < DEPTH; i++) begin
         v = v * SEED_MUL;
         mt_words[i] = v;
      end
      mt_left   = 0;
      mt_seeded = 1'b1;
   endtask

   task automatic mt_twist();
      int unsigned nx, fr;
      logic [31:0] y;
      for (int unsigned k = 0; k < DEPTH; k++) begin
         nx = (k + 1) % DEPTH;
         fr = (k + SHIFT) % DEPTH;
         y  = (mt_words[k] & 32'h8000_0000) | (mt_words[nx] & 32'h7fff_ffff);
         mt_words[k] = mt_words[fr] ^ (y >> 1) ^ (mt_words[nx][0] ? TWIST_MATRIX : 32'h0);
      end
   endtask

   task automatic mt_draw(input logic [31:0] m, output draw_result_type r);
      logic [31:0] w;
      mt_left--;
      if (mt_left >= 0 || !mt_seeded) begin
         if (mt_left < 0) begin
            mt_left = DEPTH - 1;
            mt_cursor = 10'd1;
         end
         w = (mt_cursor < DEPTH) ? mt_words[mt_cursor] : 32'h0;
         mt_cursor = mt_cursor + 10'd1;
      end else begin
         mt_twist();
         mt_left = DEPTH - 1;
         mt_cursor = 10'd1;
         w = mt_words[0];
      end
      w = mt_temper(w);
      r.zero_modulus = (m == 0);
      r.number = (m == 0) ? w : w % m;
   endtask

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("twister_random_below_modulus_unit_tb: errors");
      $finish;
   end

   // receiver: stall pattern alternates between quiet stretches and random stalls
   initial begin
      int phase_len;
      @(negedge clock);
      forever begin
         phase_len = $urandom_range(5, 60);
         stall_hold = ($urandom_range(0, 2) == 0);
         repeat (phase_len) begin
            @(negedge clock);
            rsp_stall <= stall_hold ? 1'b0 : ($urandom_range(0, 3) == 0);
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      draw_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_draws.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected rsp beat: number=%h zero=%b", rsp_number, rsp_zero_modulus);
         end else begin
            e = pending_draws.pop_front();
            if (rsp_number !== e.number || rsp_zero_modulus !== e.zero_modulus) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected number=%h zero=%b, got number=%h zero=%b",
                           e.number, e.zero_modulus, rsp_number, rsp_zero_modulus);
            end
         end
      end
   end

   // drive one beat, wait for acceptance, update predictor
   task automatic send_beat(input stim_row_type row);
      draw_result_type r;
      req_valid      <= 1'b1;
      req_op         <= row.op;
      req_seed_value <= row.seed_value;
      req_modulus    <= row.modulus;
      do @(posedge clock); while (req_stall);
      if (row.op == OP_SEED) begin
         mt_seed(row.seed_value);
      end else begin
         mt_draw(row.modulus, r);
         if (row.has_known && r.number !== row.known_number) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("table row: predictor gives %h, table says %h",
                        r.number, row.known_number);
         end
         pending_draws.push_back(r);
      end
      @(negedge clock);
   endtask

   task automatic idle_gap();
      int g;
      g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         req_op         <= 1'($urandom());
         req_seed_value <= $urandom();
         req_modulus    <= $urandom();
         repeat (g) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] rand_modulus();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'd1;
         2: return 32'hffff_ffff;
         3: return $urandom_range(2, 100);
         4: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom();
      endcase
   endfunction

   stim_row_type directed [17] = '{
      // before any seed every draw yields 0
      '{OP_DRAW, 32'h0, 32'h0,          1'b1, 32'h0},
      '{OP_DRAW, 32'h0, 32'hffff_ffff,  1'b1, 32'h0},
      '{OP_DRAW, 32'h0, 32'd1,          1'b1, 32'h0},
      '{OP_SEED, 32'h0, 32'h0,          1'b0, 32'h0},
      '{OP_DRAW, 32'h0, 32'h0,          1'b0, 32'h0},   // first draw twists
      '{OP_DRAW, 32'h0, 32'd1,          1'b1, 32'h0},
      '{OP_DRAW, 32'h0, 32'hffff_ffff,  1'b0, 32'h0},
      '{OP_DRAW, 32'h0, 32'd7,          1'b0, 32'h0},
      '{OP_SEED, 32'hffff_ffff, 32'h0,  1'b0, 32'h0},
      '{OP_DRAW, 32'h0, 32'h8000_0000,  1'b0, 32'h0},
      '{OP_DRAW, 32'hffff_ffff, 32'h0,  1'b0, 32'h0},
      '{OP_SEED, 32'h8000_0000, 32'hffff_ffff, 1'b0, 32'h0},
      '{OP_DRAW, 32'h0, 32'h0,          1'b0, 32'h0},
      '{OP_SEED, 32'h5555_5555, 32'h0,  1'b0, 32'h0},
      '{OP_SEED, 32'haaaa_aaaa, 32'h0,  1'b0, 32'h0},   // reseed back to back
      '{OP_DRAW, 32'h0, 32'd2,          1'b0, 32'h0},
      '{OP_DRAW, 32'h0, 32'd1000,       1'b0, 32'h0}
   };

   initial begin
      stim_row_type row;
      int drawn;
      int cycles;
      mt_clear();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_beat(directed[i]);
         idle_gap();
      end

      // random: mostly draws, occasional reseed; long runs cross the twist boundary
      drawn = 0;
      while (drawn < 900) begin
         row.has_known = 1'b0;
         row.known_number = '0;
         row.op = ($urandom_range(0, 199) == 0) ? OP_SEED : OP_DRAW;
         row.seed_value = $urandom();
         row.modulus = rand_modulus();
         send_beat(row);
         drawn++;
         if ($urandom_range(0, 1) == 0) idle_gap();
      end
      req_valid <= 1'b0;

      cycles = 0;
      while (pending_draws.size() != 0 && cycles < 200000) begin
         @(posedge clock);
         cycles++;
      end
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_draws.size() == 0)
         $display("twister_random_below_modulus_unit_tb: clean");
      else
         $display("twister_random_below_modulus_unit_tb: errors");
      $finish;
   end

endmodule
